FILE: rtl/core/perspective_vertex_projector_assert.svh
// Assertion macros for the projector RTL.
`ifndef PERSPECTIVE_VERTEX_PROJECTOR_ASSERT_SVH
`define PERSPECTIVE_VERTEX_PROJECTOR_ASSERT_SVH
`ifndef SYNTH
// Checked only outside reset.
`define PVP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PVP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVP_ASSERT(label, prop, msg)
`define PVP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/pvp_pkg.sv
`default_nettype none
package pvp_pkg;

    // sqrt(3)/2 in unsigned Q0.32.
    localparam logic [31:0] PVP_K = 32'd3719550787;

    // Quotient bits kept by the dividers; larger quotients always saturate.
    localparam int PVP_QB = 34;

    localparam int PVP_AXIS_NW  = 76;
    localparam int PVP_AXIS_DW  = 48;
    localparam int PVP_DEPTH_NW = 80;
    localparam int PVP_DEPTH_DW = 62;
    localparam int PVP_AXIS_SW  = 30;
    localparam int PVP_DEPTH_SW = 2;
    localparam int PVP_OUT_W    = 97;

    localparam logic PVP_ST_OK     = 1'b0;
    localparam logic PVP_ST_ZERO_Z = 1'b1;

    typedef enum logic [1:0] {
        PVP_REG_WIDTH  = 2'd0,
        PVP_REG_HEIGHT = 2'd1,
        PVP_REG_NEAR   = 2'd2,
        PVP_REG_FAR    = 2'd3
    } pvp_reg_t;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [31:0] sum;
        logic [30:0] dif;
        logic        fneg;
        logic        fzero;
        logic [62:0] nf2;
    } pvp_cfg_t;

    typedef struct packed {
        logic        zzero;
        logic        xneg;
        logic [27:0] xoff;
        logic [75:0] xnum;
        logic        yneg;
        logic [27:0] yoff;
        logic [75:0] ynum;
        logic [47:0] zdiv;
        logic        dneg;
        logic        dzero;
        logic [79:0] dnum;
        logic [61:0] dden;
    } pvp_front_t;

    function automatic logic [31:0] pvp_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] pvp_finish(input logic neg, input logic ovf,
                                                input logic [PVP_QB-1:0] q,
                                                input logic [27:0] off);
        logic signed [PVP_QB+2:0] v;
        logic signed [PVP_QB+2:0] qs;
        logic [31:0] r;
        qs = $signed({3'b000, q});
        v = neg ? -qs : qs;
        v = v + $signed({{(PVP_QB-25){1'b0}}, off});
        if (ovf)
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (v > $signed((PVP_QB+3)'(64'sd2147483647)))
            r = 32'h7FFF_FFFF;
        else if (v < $signed((PVP_QB+3)'(-64'sd2147483648)))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pvp_front.sv
`default_nettype none
module pvp_front
    import pvp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_x,
    input  wire logic [31:0] in_y,
    input  wire logic [31:0] in_z,
    input  wire pvp_cfg_t    cfg,
    output logic             out_valid,
    output pvp_front_t       out
);

    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic [31:0] x0_reg, y0_reg, z0_reg;

    // Stage 1: magnitudes and first products.
    logic [31:0] xmag, ymag, zmag;
    logic        zzero1_reg, xneg1_reg, yneg1_reg, zneg1_reg, fneg1_reg, dzero1_reg;
    logic [43:0] xprod_reg, yprod_reg;
    logic [63:0] t1_reg, t2_reg;
    logic [61:0] dden1_reg;
    logic [31:0] zmag1_reg;
    logic [27:0] xoff1_reg, yoff1_reg;

    // Stage 2: products with the field-of-view constant, depth numerator.
    logic        zzero2_reg, xneg2_reg, yneg2_reg, dneg2_reg, dzero2_reg;
    logic [53:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [63:0] pmag_next, pmag_reg;
    logic        pneg_next;
    logic [61:0] dden2_reg;
    logic [31:0] zmag2_reg;
    logic [27:0] xoff2_reg, yoff2_reg;

    pvp_front_t  out_reg;

    assign xmag = pvp_mag(x0_reg);
    assign ymag = pvp_mag(y0_reg);
    assign zmag = pvp_mag(z0_reg);

    always_comb
    begin
        if (zneg1_reg)
        begin
            pneg_next = 1'b1;
            pmag_next = t1_reg + t2_reg;
        end
        else if (t1_reg >= t2_reg)
        begin
            pneg_next = 1'b0;
            pmag_next = t1_reg - t2_reg;
        end
        else
        begin
            pneg_next = 1'b1;
            pmag_next = t2_reg - t1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= in_x;
            y0_reg <= in_y;
            z0_reg <= in_z;

            zzero1_reg <= (zmag == 32'd0);
            xneg1_reg  <= x0_reg[31];
            yneg1_reg  <= y0_reg[31];
            zneg1_reg  <= z0_reg[31];
            fneg1_reg  <= cfg.fneg;
            dzero1_reg <= cfg.fzero;
            xprod_reg  <= {12'd0, xmag} * {31'd0, cfg.height};
            yprod_reg  <= {12'd0, ymag} * {31'd0, cfg.height};
            t1_reg     <= {32'd0, cfg.sum} * {32'd0, zmag};
            t2_reg     <= {1'b0, cfg.nf2};
            dden1_reg  <= {31'd0, cfg.dif} * {30'd0, zmag};
            zmag1_reg  <= zmag;
            xoff1_reg  <= {cfg.width, 15'd0};
            yoff1_reg  <= {cfg.height, 15'd0};

            zzero2_reg <= zzero1_reg;
            xneg2_reg  <= xneg1_reg ^ zneg1_reg;
            yneg2_reg  <= yneg1_reg ^ zneg1_reg;
            // Sign of the denominator flips when the planes are out of order.
            dneg2_reg  <= pneg_next ^ (fneg1_reg ? ~zneg1_reg : zneg1_reg);
            dzero2_reg <= dzero1_reg;
            xlo_reg    <= {32'd0, xprod_reg[21:0]} * {22'd0, PVP_K};
            xhi_reg    <= {32'd0, xprod_reg[43:22]} * {22'd0, PVP_K};
            ylo_reg    <= {32'd0, yprod_reg[21:0]} * {22'd0, PVP_K};
            yhi_reg    <= {32'd0, yprod_reg[43:22]} * {22'd0, PVP_K};
            pmag_reg   <= pmag_next;
            dden2_reg  <= dden1_reg;
            zmag2_reg  <= zmag1_reg;
            xoff2_reg  <= xoff1_reg;
            yoff2_reg  <= yoff1_reg;

            out_reg.zzero <= zzero2_reg;
            out_reg.xneg  <= xneg2_reg;
            out_reg.xoff  <= xoff2_reg;
            out_reg.xnum  <= {xhi_reg, 22'd0} + {22'd0, xlo_reg};
            out_reg.yneg  <= yneg2_reg;
            out_reg.yoff  <= yoff2_reg;
            out_reg.ynum  <= {yhi_reg, 22'd0} + {22'd0, ylo_reg};
            out_reg.zdiv  <= {zmag2_reg, 16'd0};
            out_reg.dneg  <= dneg2_reg;
            out_reg.dzero <= dzero2_reg;
            out_reg.dnum  <= {pmag_reg, 16'd0};
            out_reg.dden  <= dden2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out       = out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/pvp_div.sv
`default_nettype none
module pvp_div
    import pvp_pkg::*;
#(
    parameter int NW = PVP_AXIS_NW,
    parameter int DW = PVP_AXIS_DW,
    parameter int QB = PVP_QB,
    parameter int SW = PVP_AXIS_SW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [QB-1:0]      quo,
    output logic               ovf,
    output logic [SW-1:0]      side_out
);

    localparam int W = (NW > DW + QB) ? NW : DW + QB;

    // One quotient bit per stage, most significant first.
    logic          valid_reg [0:QB];
    logic [W-1:0]  rem_reg   [0:QB-1];
    logic [DW-1:0] den_reg   [0:QB-1];
    logic [QB-1:0] quo_reg   [0:QB];
    logic          ovf_reg   [0:QB];
    logic [SW-1:0] side_reg  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= W'(num);
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= W'(num) >= (W'(den) << QB);
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_stage
        localparam int SH = QB - j;
        logic [W-1:0] trial;
        logic         take;

        assign trial = W'(den_reg[j-1]) << SH;
        assign take  = rem_reg[j-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j]  <= {quo_reg[j-1][QB-2:0], take};
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end

        if (j < QB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quo       = quo_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign side_out  = side_reg[QB];

endmodule
`default_nettype wire

FILE: rtl/core/pvp_skid.sv
`default_nettype none
`include "perspective_vertex_projector_assert.svh"
module pvp_skid
    import pvp_pkg::*;
#(
    parameter int DW = PVP_OUT_W
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_data,
    output logic               en,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [DW-1:0]      out_data
);

    logic          valid_reg;
    logic          full_reg;
    logic [DW-1:0] data_reg;
    logic [DW-1:0] skid_reg;

    // The pipeline feeding this stage only moves while the spare slot is empty.
    assign en = ~full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else if (full_reg)
        begin
            if (out_ready)
                full_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
            valid_reg <= in_valid;
        else if (in_valid)
            full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (full_reg)
        begin
            if (out_ready)
                data_reg <= skid_reg;
        end
        else if (!valid_reg || out_ready)
            data_reg <= in_data;
        else if (in_valid)
            skid_reg <= in_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `PVP_ASSERT_ALWAYS(a_full_needs_out, full_reg |-> valid_reg, "spare slot used without output")
    `PVP_ASSERT(a_drain_spare, full_reg && out_ready |=> valid_reg && !full_reg, "spare not drained")
    `PVP_ASSERT(a_catch_stall, !full_reg && in_valid && valid_reg && !out_ready |=> full_reg, "request dropped on stall")

endmodule
`default_nettype wire

FILE: rtl/core/perspective_vertex_projector.sv
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   96    point_x, point_y, point_z
// m_axis    out  96+1  tdata: screen_x, screen_y, depth_ndc; tuser: status
// cfg       in   31    cfg_addr selects width, height, near, far
//
// One request enters per cycle while s_tready is high; m_tvalid rises once it has passed
// four front stages, a divider input stage, 34 quotient stages of the three parallel
// restoring dividers, and the output register.
// rst_n clears every valid bit and loads the default viewport and planes.
// A stall on m_axis fills a one-entry spare slot and then freezes the whole pipeline.
`default_nettype none
module perspective_vertex_projector
    import pvp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // screen_x, screen_y, depth_ndc
    output logic [0:0]       m_tuser    // status
);

    // Configuration registers.
    logic [12:0] width_reg, height_reg;
    logic [30:0] near_reg, far_reg;

    // Plane terms derived every cycle from the configuration, so they are
    // settled by the time a request reaches the stage that uses them.
    logic [31:0] sum_reg;
    logic [30:0] dif_reg;
    logic        fneg_reg, fzero_reg;
    logic [62:0] nf2_reg;
    logic [61:0] nf_next;

    pvp_cfg_t    cfg;
    logic        en;
    logic        front_valid;
    pvp_front_t  front;

    logic                    xv, yv, dv;
    logic [PVP_QB-1:0]       xq, yq, dq;
    logic                    xovf, yovf, dovf;
    logic [PVP_AXIS_SW-1:0]  xside, yside;
    logic [PVP_DEPTH_SW-1:0] dside;

    logic        res_valid;
    logic        zzero;
    logic [31:0] sx, sy, sd;
    logic [PVP_OUT_W-1:0] res_data;
    logic [PVP_OUT_W-1:0] out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            near_reg   <= 31'd65536;
            far_reg    <= 31'd6553600;
        end
        else if (cfg_wen)
        begin
            case (pvp_reg_t'(cfg_addr))
                PVP_REG_WIDTH:  width_reg  <= cfg_wdata[12:0];
                PVP_REG_HEIGHT: height_reg <= cfg_wdata[12:0];
                PVP_REG_NEAR:   near_reg   <= cfg_wdata;
                PVP_REG_FAR:    far_reg    <= cfg_wdata;
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    assign nf_next = {31'd0, near_reg} * {31'd0, far_reg};

    always_ff @(posedge clk)
    begin
        sum_reg   <= {1'b0, far_reg} + {1'b0, near_reg};
        dif_reg   <= (far_reg >= near_reg) ? (far_reg - near_reg) : (near_reg - far_reg);
        fneg_reg  <= far_reg < near_reg;
        fzero_reg <= far_reg == near_reg;
        nf2_reg   <= {nf_next, 1'b0};
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.sum    = sum_reg;
    assign cfg.dif    = dif_reg;
    assign cfg.fneg   = fneg_reg;
    assign cfg.fzero  = fzero_reg;
    assign cfg.nf2    = nf2_reg;

    assign s_tready = en;

    // Clip-space products and the depth numerator.
    pvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_x      (s_tdata[31:0]),
        .in_y      (s_tdata[63:32]),
        .in_z      (s_tdata[95:64]),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out       (front)
    );

    // Perspective divides: x and y by z scaled to Q16.16, depth by (F-N)*z.
    pvp_div #(
        .NW (PVP_AXIS_NW),
        .DW (PVP_AXIS_DW),
        .QB (PVP_QB),
        .SW (PVP_AXIS_SW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (front.xnum),
        .den       (front.zdiv),
        .side_in   ({front.zzero, front.xneg, front.xoff}),
        .out_valid (xv),
        .quo       (xq),
        .ovf       (xovf),
        .side_out  (xside)
    );

    pvp_div #(
        .NW (PVP_AXIS_NW),
        .DW (PVP_AXIS_DW),
        .QB (PVP_QB),
        .SW (PVP_AXIS_SW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (front.ynum),
        .den       (front.zdiv),
        .side_in   ({1'b0, front.yneg, front.yoff}),
        .out_valid (yv),
        .quo       (yq),
        .ovf       (yovf),
        .side_out  (yside)
    );

    pvp_div #(
        .NW (PVP_DEPTH_NW),
        .DW (PVP_DEPTH_DW),
        .QB (PVP_QB),
        .SW (PVP_DEPTH_SW)
    ) u_div_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (front.dnum),
        .den       (front.dden),
        .side_in   ({front.dzero, front.dneg}),
        .out_valid (dv),
        .quo       (dq),
        .ovf       (dovf),
        .side_out  (dside)
    );

    // Sign, viewport offset and saturation. A point on the eye plane gives
    // zeros and the zero-depth status; equal planes give zero depth.
    assign res_valid = xv & yv & dv;
    assign zzero     = xside[29];
    assign sx = zzero ? 32'd0 : pvp_finish(xside[28], xovf, xq, xside[27:0]);
    assign sy = (zzero | yside[29]) ? 32'd0 : pvp_finish(yside[28], yovf, yq, yside[27:0]);
    assign sd = (zzero | dside[1]) ? 32'd0 : pvp_finish(dside[0], dovf, dq, 28'd0);
    assign res_data = {(zzero ? PVP_ST_ZERO_Z : PVP_ST_OK), sd, sy, sx};

    pvp_skid #(
        .DW (PVP_OUT_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .en        (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data[95:0];
    assign m_tuser = out_data[96:96];

endmodule
`default_nettype wire
